@@ rtl/core/fifo_with_value_delete_defines.svh @@
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef FIFO_WITH_VALUE_DELETE_DEFINES_SVH
`define FIFO_WITH_VALUE_DELETE_DEFINES_SVH

// same-cycle implication
`define FWVD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fwvd_pkg.sv @@
package fwvd_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load_val;
    logic    push_wr;
    logic    clr_count;
    logic    idx_clr;
    logic    rd_en;
    logic    idx_inc;
    logic    cmp_en;
    logic    commit;
    logic    out_load;
    logic    out_sel_entry;
    status_t out_status;
    logic    out_last;
  } fwvd_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_last;
    logic kept_all;
    logic out_free;
  } fwvd_sts_t;

endpackage

@@ rtl/core/fwvd_datapath.sv @@
module fwvd_datapath #(
  parameter int DEPTH = fwvd_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [fwvd_pkg::DATA_W-1:0] s_value,
  input  fwvd_pkg::fwvd_ctl_t               ctl,
  output fwvd_pkg::fwvd_sts_t               sts,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fwvd_pkg::DATA_W-1:0]       m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast
);
  import fwvd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     kept;

  logic              keep_hit;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  // during delete a survivor moves down to the kept position
  assign keep_hit = ctl.cmp_en && (rd_data != val_q);
  assign wr_en    = ctl.push_wr || keep_hit;
  assign wr_addr  = ctl.push_wr ? count[AW-1:0] : kept[AW-1:0];
  assign wr_data  = ctl.push_wr ? s_value : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clr_count) begin
      count <= '0;
    end else if (ctl.push_wr) begin
      count <= count + CW'(1);
    end else if (ctl.commit) begin
      count <= kept;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_val) begin
      val_q <= s_value;
    end
    if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (ctl.idx_clr) begin
      kept <= '0;
    end else if (keep_hit) begin
      kept <= kept + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tdata <= ctl.out_sel_entry ? rd_data : '0;
      m_tuser <= ctl.out_status;
      m_tlast <= ctl.out_last;
    end
  end

  assign sts.count_zero = (count == '0);
  assign sts.full       = (count == CW'(DEPTH));
  assign sts.idx_last   = ((idx + CW'(1)) == count);
  assign sts.kept_all   = (kept == count);
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

@@ rtl/core/fwvd_ctrl.sv @@
module fwvd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  fwvd_pkg::cmd_t      s_cmd,
  input  fwvd_pkg::fwvd_sts_t sts,
  output fwvd_pkg::fwvd_ctl_t ctl
);
  import fwvd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST_RD,
    S_LIST_OUT,
    S_DEL_RD,
    S_DEL_CMP,
    S_DEL_END,
    S_RESP
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t resp_status;
  logic    accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.out_status = resp_status;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.load_val = 1'b1;
          unique case (s_cmd)
            CMD_PUSH: begin
              ctl.push_wr = !sts.full;
              state_next  = S_RESP;
            end
            CMD_LIST: begin
              ctl.idx_clr = 1'b1;
              state_next  = sts.count_zero ? S_RESP : S_LIST_RD;
            end
            CMD_DELETE: begin
              ctl.idx_clr = 1'b1;
              state_next  = sts.count_zero ? S_RESP : S_DEL_RD;
            end
            CMD_CLEAR: begin
              ctl.clr_count = 1'b1;
              state_next    = S_RESP;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_LIST_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (sts.out_free) begin
          ctl.out_load      = 1'b1;
          ctl.out_sel_entry = 1'b1;
          ctl.out_status    = ST_OK;
          ctl.out_last      = sts.idx_last;
          ctl.idx_inc       = 1'b1;
          state_next        = sts.idx_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_DEL_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        ctl.cmp_en  = 1'b1;
        ctl.idx_inc = 1'b1;
        state_next  = sts.idx_last ? S_DEL_END : S_DEL_RD;
      end
      S_DEL_END: begin
        ctl.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= ST_OK;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (s_cmd)
          CMD_PUSH:   resp_status <= sts.full ? ST_FULL : ST_OK;
          CMD_LIST:   resp_status <= sts.count_zero ? ST_EMPTY : ST_OK;
          CMD_DELETE: resp_status <= sts.count_zero ? ST_EMPTY : ST_OK;
          CMD_CLEAR:  resp_status <= ST_OK;
          default:    resp_status <= ST_OK;
        endcase
      end else if (state == S_DEL_END) begin
        resp_status <= sts.kept_all ? ST_NOT_FOUND : ST_OK;
      end
    end
  end

endmodule

@@ rtl/core/fifo_with_value_delete.sv @@
// push, clear and empty-queue replies: one result, loaded from the response state once the output register is free
// list: one result per stored entry, each a registered store read, then an output load once free
// delete: one read and one compare per entry, then a commit before the result
// next command is taken once the current one has loaded its final result
// rst (synchronous) empties the queue and idles the controller; store contents are kept
`include "fifo_with_value_delete_defines.svh"

module fifo_with_value_delete #(
  parameter int DEPTH = fwvd_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fwvd_pkg::DATA_W-1:0] s_tdata,  // value
  input  logic [1:0]                  s_tuser,  // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fwvd_pkg::DATA_W-1:0] m_tdata,  // entry
  output logic [1:0]                  m_tuser,  // status
  output logic                        m_tlast
);
  import fwvd_pkg::*;

  fwvd_ctl_t ctl;
  fwvd_sts_t sts;

  fwvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_cmd    (cmd_t'(s_tuser)),
    .sts      (sts),
    .ctl      (ctl)
  );

  fwvd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_value  (s_tdata),
    .ctl      (ctl),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `FWVD_ASSERT_SAME(a_load_when_free, ctl.out_load, sts.out_free, "result loaded over a pending one")
  `FWVD_ASSERT_SAME(a_no_push_full, ctl.push_wr, !sts.full, "write into a full queue")
  `FWVD_ASSERT_SAME(a_cmp_after_read, ctl.cmp_en, $past(ctl.rd_en), "compare without a read")
  `FWVD_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready right after a transfer")

endmodule

@@ sim/fifo_with_value_delete_checker.sv @@
module fifo_with_value_delete_checker #(
  parameter int DEPTH = fwvd_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [fwvd_pkg::DATA_W-1:0] s_tdata,  // value
  input  logic [1:0]                  s_tuser,  // command
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [fwvd_pkg::DATA_W-1:0] m_tdata,  // entry
  input  logic [1:0]                  m_tuser,  // status
  input  logic                        m_tlast,
  output int                          fail_count,
  output int                          pending
);
  import fwvd_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] entry;
    status_t           status;
    logic              last;
  } reply_t;

  reply_t            replies[$];
  logic [DATA_W-1:0] shadow_store[DEPTH];
  int                shadow_fill = 0;
  int                errors = 0;

  function automatic void add_reply(logic [DATA_W-1:0] entry, status_t status, logic last);
    reply_t r;
    r.entry  = entry;
    r.status = status;
    r.last   = last;
    replies.push_back(r);
  endfunction

  // updates the shadow queue and queues every reply the command causes
  function automatic void queue_command_replies(cmd_t cmd, logic [DATA_W-1:0] val);
    int kept;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          add_reply('0, ST_FULL, 1'b1);
        end else begin
          shadow_store[shadow_fill] = val;
          shadow_fill++;
          add_reply('0, ST_OK, 1'b1);
        end
      end
      CMD_LIST: begin
        if (shadow_fill == 0) begin
          add_reply('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            add_reply(shadow_store[i], ST_OK, i == shadow_fill - 1);
        end
      end
      CMD_DELETE: begin
        if (shadow_fill == 0) begin
          add_reply('0, ST_EMPTY, 1'b1);
        end else begin
          kept = 0;
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_store[i] != val) begin
              shadow_store[kept] = shadow_store[i];
              kept++;
            end
          end
          if (kept == shadow_fill) begin
            add_reply('0, ST_NOT_FOUND, 1'b1);
          end else begin
            shadow_fill = kept;
            add_reply('0, ST_OK, 1'b1);
          end
        end
      end
      default: begin
        shadow_fill = 0;
        add_reply('0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      shadow_fill = 0;
      replies.delete();
    end else begin
      if (s_tvalid && s_tready)
        queue_command_replies(cmd_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) begin
        if (replies.size() == 0) begin
          $error("result transfer with nothing expected: entry %0d status %0d last %0b",
                 $signed(m_tdata), m_tuser, m_tlast);
          errors++;
        end else begin
          want = replies.pop_front();
          if (m_tdata !== want.entry) begin
            $error("entry: expected %0d, actual %0d", $signed(want.entry), $signed(m_tdata));
            errors++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= replies.size();
  end

endmodule

@@ sim/fifo_with_value_delete_test.sv @@
module fifo_with_value_delete_test;
  import fwvd_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;  // value
  logic [1:0]        s_tuser = '0;  // command
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;       // entry
  logic [1:0]        m_tuser;       // status
  logic              m_tlast;

  int   fail_count;
  int   pending;
  logic sender_burst = 1'b0;
  logic recv_burst = 1'b0;
  logic hold_req = 1'b0;

  fifo_with_value_delete dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  fifo_with_value_delete_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // valid stays high from one command to the next when there is no gap
  task automatic send_cmd(input cmd_t cmd, input logic [DATA_W-1:0] val);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
  endtask

  // pending is registered in the checker, so the task lets it update before polling it
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // small signed values so deletes hit often, plus the extremes
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned       sel;
    logic [DATA_W-1:0] corners[4];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    sel = $urandom_range(0, 9);
    if (sel < 6)
      return $urandom_range(0, 7) - 4;
    if (sel < 8)
      return corners[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  initial begin : receiver
    int wait_cycles;
    int taken;
    taken = 0;
    forever begin
      if (taken % 20 == 0)
        recv_burst = ($urandom_range(0, 2) == 0);
      wait_cycles = recv_burst ? 0 : $urandom_range(0, 13);
      if (hold_req) begin
        wait_cycles = 300;
        hold_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, head, tail and multi-match deletes
    send_cmd(CMD_LIST, 32'hFFFF_FFFF);
    send_cmd(CMD_DELETE, 32'd7);
    send_cmd(CMD_PUSH, 32'h8000_0000);
    send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH, 32'h0000_0000);
    send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH, 32'h8000_0000);
    send_cmd(CMD_LIST, 32'h0000_0000);
    send_cmd(CMD_DELETE, 32'h1234_5678);
    send_cmd(CMD_DELETE, 32'h8000_0000);
    send_cmd(CMD_LIST, 32'h5555_5555);
    send_cmd(CMD_DELETE, 32'hFFFF_FFFF);
    send_cmd(CMD_LIST, 32'hAAAA_AAAA);
    send_cmd(CMD_PUSH, 32'h7FFF_FFFF);
    send_cmd(CMD_DELETE, 32'h7FFF_FFFF);
    send_cmd(CMD_LIST, 32'h0000_0000);
    send_cmd(CMD_DELETE, 32'h0000_0000);
    send_cmd(CMD_LIST, 32'h0000_0000);
    send_cmd(CMD_PUSH, 32'h5555_5555);
    send_cmd(CMD_PUSH, 32'hAAAA_AAAA);
    send_cmd(CMD_CLEAR, 32'hFFFF_FFFF);
    send_cmd(CMD_LIST, 32'h0000_0000);
    send_cmd(CMD_CLEAR, 32'h0000_0000);
    wait_all_results();

    // receiver holds off while pushes run past full
    hold_req = 1'b1;
    sender_burst = 1'b1;
    for (int n = 0; n < DEPTH_DEF + 4; n++)
      send_cmd(CMD_PUSH, pick_value());
    wait_all_results();
    sender_burst = 1'b0;
    send_cmd(CMD_LIST, $urandom());
    send_cmd(CMD_PUSH, pick_value());
    send_cmd(CMD_DELETE, pick_value());
    send_cmd(CMD_PUSH, pick_value());
    send_cmd(CMD_LIST, $urandom());

    for (int n = 0; n < 170; n++) begin
      if (n % 20 == 0)
        sender_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 48)
        send_cmd(CMD_PUSH, pick_value());
      else if (r < 62)
        send_cmd(CMD_LIST, $urandom());
      else if (r < 92)
        send_cmd(CMD_DELETE, pick_value());
      else
        send_cmd(CMD_CLEAR, $urandom());
    end

    wait_all_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #(20 * 1500000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
